// ===== src/box_split_among_ranks_defines.svh =====
// Assertion macros for the box splitter checker.
// Needs clk and arst_n in the scope of each use.
`ifndef BOX_SPLIT_AMONG_RANKS_DEFINES_SVH
`define BOX_SPLIT_AMONG_RANKS_DEFINES_SVH

// Condition now implies consequence at the same edge
`define BSAR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box splitter check failed");

// Condition now implies consequence at the next edge
`define BSAR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box splitter check failed");

`endif

// ===== src/bsar_pkg.sv =====
// Shared types and constants of the box splitter.
// Used by bsar_div and box_split_among_ranks.
package bsar_pkg;

	localparam int FD = 4;   // dimensions carried on the ports
	localparam int CW = 16;  // coordinate field width
	localparam int PW = 7;   // process count width
	localparam int RW = 6;   // rank width

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RANK, S_BELOW, S_BELOW_W, S_UP, S_UP_W,
		S_SHARE, S_SHARE_W, S_EMIT, S_ADV, S_CARRY
	} state_t;

	typedef struct packed {
		logic [RW-1:0]       rank;
		logic [FD-1:0][CW-1:0] start;
		logic [FD-1:0][CW-1:0] extent;
		logic                last;
		logic                err;
	} piece_t;

endpackage

// ===== src/bsar_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bsar_pkg for the coordinate width.
module bsar_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [bsar_pkg::CW-1:0] dividend,
	input  logic [bsar_pkg::CW-1:0] divisor,
	output logic                    done,
	output logic [bsar_pkg::CW-1:0] quotient
);

	localparam int NW = $clog2(bsar_pkg::CW + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [NW-1:0]           cnt_q;
	logic [bsar_pkg::CW:0]   rem_q;
	logic [bsar_pkg::CW-1:0] quo_q;
	logic [bsar_pkg::CW-1:0] dvs_q;
	logic [bsar_pkg::CW:0]   trial;
	logic                    fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q[bsar_pkg::CW-1:0], quo_q[bsar_pkg::CW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(bsar_pkg::CW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[bsar_pkg::CW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/box_split_among_ranks.sv =====
// Box splitter: walks ranks 0 upward, one result per rank (or for the target only).
// Each rank runs up to five divisions on the one shared divider plus the offset carry
// walk. One request at a time: s_tready is high only when idle, and each result waits
// in the output register until it is taken.
// arst_n clears the sequencer and the handshake flags; no state survives a request.
module box_split_among_ranks #(
	parameter int MAX_DIMS   = 4,
	parameter int MAX_PROCS  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// dim_count[2:0], proc_count[9:3], target_rank[15:10], all_ranks[16],
	// box_min_0..3[80:17], box_max_0..3[144:81], zeros above
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rank[5:0], start_0..3[69:6], extent_0..3[133:70], zeros above
	output logic [135:0] m_tdata,
	output logic         m_tlast,
	// error
	output logic [0:0]   m_tuser
);

	localparam int FD   = bsar_pkg::FD;
	localparam int CW   = bsar_pkg::CW;
	localparam int PW   = bsar_pkg::PW;
	localparam int RW   = bsar_pkg::RW;
	localparam int DLIM = (MAX_DIMS < FD) ? MAX_DIMS : FD;
	localparam logic [CW-1:0] CMASK = (COORD_BITS >= CW) ? {CW{1'b1}} :
		CW'((32'd1 << COORD_BITS) - 32'd1);

	bsar_pkg::state_t state_q, state_d;
	bsar_pkg::piece_t out_q;

	logic [2:0]           dd_q;
	logic [PW-1:0]        p_q;
	logic [RW-1:0]        tgt_q;
	logic                 all_q;
	logic [FD-1:0][CW-1:0] bmin_q;
	logic [FD-1:0][CW-1:0] size_q;
	logic [FD-1:0][CW-1:0] asg_q;
	logic [RW-1:0]        lastr_q;
	logic [RW-1:0]        j_q;
	logic [PW-1:0]        n_q;
	logic [3:0]           k_q;   // signed walk index, -1 .. FD
	logic [1:0]           i_q;
	logic [1:0]           w_q;
	logic [CW-1:0]        share_q;
	logic                 fin_q;

	// Input fields
	logic [2:0]           in_d;
	logic [PW-1:0]        in_p;
	logic [2:0]           dsat;
	logic [PW-1:0]        psat;
	logic [FD-1:0][CW-1:0] in_lo, in_hi;

	// Working signals
	logic                 accept;
	logic [1:0]           ridx;
	logic [CW-1:0]        rem_r;
	logic                 kneg, kge, go, n_gt, reject, is_last, carry, anynz, bad;
	logic [1:0]           wsel;
	logic                 div_start, div_done;
	logic [CW-1:0]        div_a, div_b, div_q;

	assign in_d = s_tdata[2:0];
	assign in_p = s_tdata[9:3];
	assign dsat = (in_d == 3'd0) ? 3'd1 : ((in_d > 3'(DLIM)) ? 3'(DLIM) : in_d);
	assign psat = (in_p > PW'(MAX_PROCS)) ? PW'(MAX_PROCS) : in_p;

	always_comb begin
		for (int d = 0; d < FD; d++) begin
			in_lo[d] = s_tdata[17 + CW*d +: CW] & CMASK;
			in_hi[d] = s_tdata[17 + CW*(FD+d) +: CW] & CMASK;
		end
	end

	assign accept  = s_tvalid && s_tready;
	assign kneg    = k_q[3];
	assign kge     = !kneg && (k_q[2:0] >= dd_q);
	assign go      = {1'b0, i_q} < {1'b0, w_q};
	assign ridx    = (state_q == bsar_pkg::S_BELOW) ? i_q : k_q[1:0];
	assign rem_r   = (size_q[ridx] > asg_q[ridx]) ? size_q[ridx] - asg_q[ridx] : '0;
	assign n_gt    = CW'(n_q) > rem_r;
	assign reject  = (p_q == '0) || (!all_q && {1'b0, tgt_q} >= p_q);
	assign is_last = j_q == lastr_q;
	assign carry   = !kneg && (asg_q[k_q[1:0]] == size_q[k_q[1:0]]);

	// Highest dimension with a nonzero offset, and whether any is nonzero
	always_comb begin
		wsel  = '0;
		anynz = 1'b0;
		for (int d = 0; d < FD; d++) begin
			if (asg_q[d] != '0) begin
				wsel  = 2'(d);
				anynz = 1'b1;
			end
		end
	end

	// Conditions that stop the walk
	always_comb begin
		case (state_q)
			bsar_pkg::S_RANK:  bad = (n_q != '0) && kneg;
			bsar_pkg::S_BELOW: bad = go ? (rem_r == '0) : (n_q == '0);
			bsar_pkg::S_UP:    bad = kge || (n_gt && rem_r == '0);
			default:           bad = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bsar_pkg::S_IDLE:    if (accept) state_d = bsar_pkg::S_CHECK;
			bsar_pkg::S_CHECK:   state_d = reject ? bsar_pkg::S_EMIT : bsar_pkg::S_RANK;
			bsar_pkg::S_RANK: begin
				if (n_q == '0)  state_d = bsar_pkg::S_BELOW;
				else if (bad)   state_d = bsar_pkg::S_EMIT;
				else            state_d = bsar_pkg::S_SHARE;
			end
			bsar_pkg::S_BELOW: begin
				if (bad)        state_d = bsar_pkg::S_EMIT;
				else if (go)    state_d = bsar_pkg::S_BELOW_W;
				else            state_d = bsar_pkg::S_UP;
			end
			bsar_pkg::S_BELOW_W: if (div_done) state_d = bsar_pkg::S_BELOW;
			bsar_pkg::S_UP: begin
				if (bad)        state_d = bsar_pkg::S_EMIT;
				else if (n_gt)  state_d = bsar_pkg::S_UP_W;
				else            state_d = bsar_pkg::S_SHARE;
			end
			bsar_pkg::S_UP_W:    if (div_done) state_d = bsar_pkg::S_UP;
			bsar_pkg::S_SHARE:   state_d = bsar_pkg::S_SHARE_W;
			bsar_pkg::S_SHARE_W: begin
				if (div_done)
					state_d = (!is_last && all_q) ? bsar_pkg::S_EMIT : bsar_pkg::S_ADV;
			end
			bsar_pkg::S_EMIT: begin
				if (m_tready) state_d = fin_q ? bsar_pkg::S_IDLE : bsar_pkg::S_ADV;
			end
			bsar_pkg::S_ADV:     state_d = bsar_pkg::S_CARRY;
			bsar_pkg::S_CARRY: begin
				if (!carry) state_d = is_last ? bsar_pkg::S_EMIT : bsar_pkg::S_RANK;
			end
			default:             state_d = bsar_pkg::S_IDLE;
		endcase
	end

	// Handshake and divider launch
	always_comb begin
		s_tready  = state_q == bsar_pkg::S_IDLE;
		m_tvalid  = state_q == bsar_pkg::S_EMIT;
		div_start = 1'b0;
		div_a     = rem_r;
		div_b     = CW'(n_q);
		case (state_q)
			bsar_pkg::S_BELOW, bsar_pkg::S_UP: begin
				div_start = !bad && ((state_q == bsar_pkg::S_BELOW) ? go : n_gt);
				div_a     = CW'(n_q);
				div_b     = rem_r;
			end
			bsar_pkg::S_SHARE: div_start = 1'b1;
			default: ;
		endcase
	end

	bsar_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bsar_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// Walk registers and result record
	always_ff @(posedge clk) begin
		if (bad) begin
			out_q <= '{rank: j_q, start: '0, extent: '0, last: 1'b1, err: 1'b1};
			fin_q <= 1'b1;
		end else begin
			case (state_q)
				bsar_pkg::S_IDLE: begin
					if (accept) begin
						dd_q  <= dsat;
						p_q   <= psat;
						tgt_q <= s_tdata[15:10];
						all_q <= s_tdata[16];
						for (int d = 0; d < FD; d++) begin
							if (3'(d) < dsat) begin
								bmin_q[d] <= in_lo[d];
								size_q[d] <= (in_hi[d] >= in_lo[d]) ? in_hi[d] - in_lo[d] : '0;
							end else begin
								bmin_q[d] <= '0;
								size_q[d] <= '0;
							end
						end
					end
				end
				bsar_pkg::S_CHECK: begin
					out_q      <= '{rank: (p_q == '0 && all_q) ? '0 : tgt_q, start: '0,
						extent: '0, last: 1'b1, err: 1'b1};
					fin_q      <= 1'b1;
					lastr_q    <= all_q ? RW'(p_q - 1'b1) : tgt_q;
					j_q        <= '0;
					n_q        <= '0;
					k_q        <= '0;
					asg_q      <= '0;
				end
				bsar_pkg::S_RANK: begin
					if (n_q == '0) begin
						w_q <= wsel;
						n_q <= p_q - PW'(j_q);
						i_q <= '0;
					end
				end
				bsar_pkg::S_BELOW: if (!go) k_q <= {2'b00, w_q};
				bsar_pkg::S_BELOW_W: begin
					if (div_done) begin
						n_q <= div_q[PW-1:0];
						i_q <= i_q + 1'b1;
					end
				end
				bsar_pkg::S_UP_W: begin
					if (div_done) begin
						n_q <= div_q[PW-1:0];
						k_q <= k_q + 1'b1;
					end
				end
				bsar_pkg::S_SHARE_W: begin
					if (div_done) begin
						share_q    <= div_q;
						n_q        <= n_q - 1'b1;
						out_q.rank <= j_q;
						out_q.last <= is_last;
						out_q.err  <= 1'b0;
						fin_q      <= is_last;
						for (int d = 0; d < FD; d++) begin
							if (3'(d) < dd_q) begin
								out_q.start[d] <= (asg_q[d] + bmin_q[d]) & CMASK;
								if (3'(d) < k_q[2:0])       out_q.extent[d] <= CW'(1);
								else if (3'(d) == k_q[2:0]) out_q.extent[d] <= div_q & CMASK;
								else                        out_q.extent[d] <= size_q[d];
							end else begin
								out_q.start[d]  <= '0;
								out_q.extent[d] <= '0;
							end
						end
					end
				end
				bsar_pkg::S_ADV: asg_q[k_q[1:0]] <= asg_q[k_q[1:0]] + share_q;
				bsar_pkg::S_CARRY: begin
					if (carry) begin
						// Wrap this offset and carry into the next lower dimension
						asg_q[k_q[1:0]] <= '0;
						if (k_q[1:0] != 2'd0)
							asg_q[k_q[1:0] - 2'd1] <= asg_q[k_q[1:0] - 2'd1] + 1'b1;
						k_q <= k_q - 1'b1;
					end else if (is_last) begin
						out_q.err <= all_q && anynz;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Pack the result
	assign m_tdata    = {2'b00, out_q.extent, out_q.start, out_q.rank};
	assign m_tlast    = out_q.last;
	assign m_tuser[0] = out_q.err;

endmodule

// ===== src/bsar_checker.sv =====
// Port-level checks of the box splitter, bound to the top level.
// Uses the assertion macros of box_split_among_ranks_defines.svh.
`include "box_split_among_ranks_defines.svh"

module bsar_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic       m_tlast,
	input logic [0:0] m_tuser
);

	// Hold a result until taken
	`BSAR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	// Never take a request while a result waits
	`BSAR_ASSERT_NOW(a_busy_out, m_tvalid, !s_tready)
	// An error result always closes the request
	`BSAR_ASSERT_NOW(a_err_last, m_tvalid && m_tuser[0], m_tlast)
	// Drop ready after a request transfer
	`BSAR_ASSERT_NEXT(a_busy_in, s_tvalid && s_tready, !s_tready && !m_tvalid)

endmodule

bind box_split_among_ranks bsar_checker u_bsar_checker (.*);

// ===== bench/tb.sv =====
// Testbench for box_split_among_ranks: random and directed box split requests.
// Depends on box_split_among_ranks; predicts every piece in a function.
module tb;

	typedef struct {
		logic [2:0]  dims;
		logic [6:0]  procs;
		logic [5:0]  target;
		logic        all;
		logic [15:0] bmin [4];
		logic [15:0] bmax [4];
	} split_req_t;

	typedef struct {
		logic [5:0]  rank;
		logic [15:0] start [4];
		logic [15:0] ext [4];
		logic        last;
		logic        err;
	} piece_rec_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tlast;
	logic [0:0]   m_tuser;

	split_req_t req_queue [$];
	piece_rec_t piece_queue [$];
	int  fail_count;
	bit  stim_done;
	bit  quiet;
	int  src_gap;
	int  snk_gap;

	box_split_among_ranks i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [151:0] pack_req(split_req_t r);
		logic [151:0] v;
		v = '0;
		v[2:0] = r.dims;
		v[9:3] = r.procs;
		v[15:10] = r.target;
		v[16] = r.all;
		for (int i = 0; i < 4; i++) begin
			v[17 + 16*i +: 16] = r.bmin[i];
			v[81 + 16*i +: 16] = r.bmax[i];
		end
		return v;
	endfunction

	function automatic void push_piece(logic [5:0] rank, logic [15:0] st[4],
			logic [15:0] ex[4], logic last, logic err);
		piece_rec_t p;
		p.rank = rank;
		p.start = st;
		p.ext = ex;
		p.last = last;
		p.err = err;
		piece_queue.push_back(p);
	endfunction

	// Work out all pieces of one request and queue them
	function automatic void split_box(split_req_t r);
		int unsigned sz [4];
		int unsigned off [4];
		int unsigned lo [4];
		logic [15:0] st [4];
		logic [15:0] ex [4];
		logic [15:0] zv [4];
		int unsigned nd, np, tg, lastr, n, rm, share;
		int k, w, i, emitted;
		bit bad;
		foreach (zv[q]) zv[q] = '0;
		foreach (sz[q]) begin sz[q] = 0; off[q] = 0; lo[q] = 0; end
		nd = 32'(r.dims);
		if (nd < 1) nd = 1;
		if (nd > 4) nd = 4;
		np = 32'(r.procs);
		if (np > 64) np = 64;
		tg = 32'(r.target);
		for (i = 0; i < nd; i++) begin
			lo[i] = 32'(r.bmin[i]);
			sz[i] = (r.bmax[i] >= r.bmin[i]) ? 32'(r.bmax[i]) - 32'(r.bmin[i]) : 0;
		end
		if (np == 0) begin
			push_piece(r.all ? 6'd0 : r.target, zv, zv, 1'b1, 1'b1);
			return;
		end
		if (!r.all && tg >= np) begin
			push_piece(r.target, zv, zv, 1'b1, 1'b1);
			return;
		end
		lastr = r.all ? np - 1 : tg;
		n = 0;
		k = 0;
		emitted = 0;
		for (int unsigned j = 0; j <= lastr; j++) begin
			bad = 0;
			if (n == 0) begin
				w = 0;
				for (i = nd - 1; i >= 0; i--)
					if (off[i] != 0) begin w = i; break; end
				n = np - j;
				for (i = 0; i < w && !bad; i++) begin
					rm = (sz[i] > off[i]) ? sz[i] - off[i] : 0;
					if (rm == 0) bad = 1; else n = n / rm;
				end
				if (!bad && n == 0) bad = 1;
				if (!bad) begin
					for (k = w; k < nd; k++) begin
						rm = (sz[k] > off[k]) ? sz[k] - off[k] : 0;
						if (n > rm) begin
							if (rm == 0) begin bad = 1; break; end
							n = n / rm;
						end else break;
					end
					if (k >= nd) bad = 1;
				end
			end else if (k < 0 || k >= nd) begin
				bad = 1;
			end
			if (bad) begin
				push_piece(j[5:0], zv, zv, 1'b1, 1'b1);
				return;
			end
			rm = (sz[k] > off[k]) ? sz[k] - off[k] : 0;
			share = rm / n;
			for (i = 0; i < 4; i++) begin
				if (i >= nd) begin
					st[i] = '0;
					ex[i] = '0;
				end else begin
					st[i] = 16'(off[i] + lo[i]);
					ex[i] = (i < k) ? 16'd1 : (i == k) ? 16'(share) : 16'(sz[i]);
				end
			end
			if (r.all || j == lastr) begin
				push_piece(j[5:0], st, ex, j == lastr, 1'b0);
				emitted++;
			end
			off[k] += share;
			n--;
			while (off[k] == sz[k]) begin
				off[k] = 0;
				k--;
				if (k >= 0) off[k]++;
				else break;
			end
		end
		// Leftover offsets flag the final piece
		if (r.all && emitted > 0)
			for (i = 0; i < nd; i++)
				if (off[i] != 0) begin
					piece_queue[$].err = 1'b1;
					break;
				end
	endfunction

	function automatic split_req_t rand_req();
		split_req_t r;
		int unsigned span;
		r.dims = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
			: $urandom_range(1, 4));
		case ($urandom_range(0, 9))
			0: r.procs = 7'($urandom_range(65, 127));
			1: r.procs = '0;
			default: r.procs = 7'($urandom_range(1, 64));
		endcase
		r.all = ($urandom_range(0, 3) == 0);
		r.target = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
			: $urandom_range(0, (r.procs > 0 && r.procs <= 64) ? r.procs - 1 : 63));
		for (int i = 0; i < 4; i++) begin
			r.bmin[i] = 16'($urandom_range(0, 65535));
			case ($urandom_range(0, 5))
				0: span = $urandom_range(0, 3);
				1: span = $urandom_range(0, 65535);
				default: span = $urandom_range(1, 40);
			endcase
			r.bmax[i] = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(0, 65535))
				: 16'(r.bmin[i] + span);
			if (r.bmax[i] < r.bmin[i] && $urandom_range(0, 3) != 0) r.bmin[i] = '0;
		end
		return r;
	endfunction

	// Fill the request queue: directed cases first, then random ones
	initial begin
		split_req_t r;
		for (int c = 0; c < 16; c++) begin
			r = rand_req();
			r.dims = 3'((c % 4) + 1);
			r.all = c[0];
			case (c)
				0: begin r.procs = '0; r.all = 0; r.target = 6'd63; end
				1: r.procs = '0;
				2: begin r.procs = 7'd5; r.target = 6'd5; end
				3: begin r.procs = 7'd127; r.dims = 3'd7; end
				4: begin r.procs = 7'd64; r.target = 6'd63; end
				5: begin r.procs = 7'd1; r.dims = 3'd0; end
				default: r.procs = 7'($urandom_range(1, 64));
			endcase
			for (int i = 0; i < 4; i++) begin
				if (c == 6) begin r.bmin[i] = 16'hFFFF; r.bmax[i] = 16'h0000; end
				else if (c == 7) begin r.bmin[i] = 16'd0; r.bmax[i] = 16'hFFFF; end
				else if (c == 8) begin r.bmin[i] = 16'hFFF0; r.bmax[i] = 16'hFFFF; end
				else if (c == 9) begin r.bmin[i] = 16'd7; r.bmax[i] = 16'd7; end
				else if (c == 10) begin r.bmin[i] = 16'd0; r.bmax[i] = 16'd2; end
			end
			req_queue.push_back(r);
		end
		for (int c = 0; c < 300; c++) req_queue.push_back(rand_req());
	end

	// Drive requests onto the slave side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					s_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (req_queue.size() > 0) begin
					split_box(req_queue[0]);
					s_tdata <= pack_req(req_queue.pop_front());
					s_tvalid <= 1'b1;
					if (!quiet && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 14);
				end else begin
					s_tvalid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
		end
	end

	// Check pieces on the master side and throttle tready
	always @(posedge clk or negedge arst_n) begin
		piece_rec_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (piece_queue.size() == 0) begin
					$error("unexpected piece, rank %0d", m_tdata[5:0]);
					fail_count++;
				end else begin
					e = piece_queue.pop_front();
					if (m_tdata[5:0] !== e.rank) begin
						$error("rank: expected %0d, got %0d", e.rank, m_tdata[5:0]);
						fail_count++;
					end
					for (int i = 0; i < 4; i++) begin
						if (m_tdata[6 + 16*i +: 16] !== e.start[i]) begin
							$error("start_%0d: expected %0d, got %0d", i, e.start[i],
								m_tdata[6 + 16*i +: 16]);
							fail_count++;
						end
						if (m_tdata[70 + 16*i +: 16] !== e.ext[i]) begin
							$error("extent_%0d: expected %0d, got %0d", i, e.ext[i],
								m_tdata[70 + 16*i +: 16]);
							fail_count++;
						end
					end
					if (m_tlast !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, m_tlast);
						fail_count++;
					end
					if (m_tuser[0] !== e.err) begin
						$error("error: expected %0d, got %0d", e.err, m_tuser[0]);
						fail_count++;
					end
				end
			end
			if (snk_gap > 0) begin
				m_tready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				snk_gap <= $urandom_range(0, 13);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Reset, then wait for the run to drain
	initial begin
		fail_count = 0;
		stim_done = 0;
		quiet = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (req_queue.size() < 40);
		quiet = 1;
		wait (stim_done && piece_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog against a hang
	initial begin
		#200000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/bsar_pkg.sv
src/bsar_div.sv
src/box_split_among_ranks.sv
src/bsar_checker.sv
bench/tb.sv
